// File: hw/rtl/lbm_d2q5_cell_collision_core_assert.svh
// ----------------------------------------------------------------------------
// lbm_d2q5_cell_collision_core_assert.svh
// Assertion macros shared by the collision core checkers.
// ----------------------------------------------------------------------------
`ifndef LBM_D2Q5_CELL_COLLISION_CORE_ASSERT_SVH
`define LBM_D2Q5_CELL_COLLISION_CORE_ASSERT_SVH

// Clocked assertion, off while reset is asserted
`define LBMC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define LBMC_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/lbmc_pkg.sv
// ----------------------------------------------------------------------------
// lbmc_pkg
// Widths, codes and types of the D2Q5 cell collision core.
// ----------------------------------------------------------------------------
package lbmc_pkg;

	// Field widths
	localparam int VALUE_W    = 16;
	localparam int KIND_W     = 2;
	localparam int SRC_W      = 15;
	localparam int INV_TAU_W  = 15;
	localparam int DAMP_W     = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	// Internal widths: density sums five values, momenta two
	localparam int RHO_W = VALUE_W + 3;
	localparam int J_W   = VALUE_W + 1;
	localparam int EQ_W  = RHO_W + 1;

	// Q2.13 fixed point
	localparam int FRAC_W = 13;
	localparam int ONE_Q13 = 8192;

	// Equilibrium constants at scale 2^16: sound speed squared and twice the rest weight
	localparam int C2_Q16      = 3775;
	localparam int AUX0_X2_Q16 = 115974;
	localparam int EQ_SHIFT    = 17;

	// Register reset values
	localparam logic [INV_TAU_W-1:0] INV_TAU_RST = INV_TAU_W'(16384);
	localparam logic [DAMP_W-1:0]    DAMP_RST    = DAMP_W'(7782);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INV_TAU = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 2'd1;

	// Cell kinds; the unused code behaves as interior
	typedef logic [KIND_W-1:0] kind_t;
	localparam kind_t KIND_INTERIOR = 2'd0;
	localparam kind_t KIND_WALL     = 2'd1;
	localparam kind_t KIND_SOURCE   = 2'd2;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic signed [EQ_W-1:0]    eq_t;

	// Collision weights handed to each direction lane
	typedef struct packed {
		logic [INV_TAU_W-1:0] inv_tau;
		logic [DAMP_W-1:0]    damping;
	} cfg_t;

endpackage

// File: hw/rtl/lbmc_relax.sv
// ----------------------------------------------------------------------------
// lbmc_relax
// One direction lane: relaxes toward equilibrium or reflects at walls and rounds,
// or passes the source equilibrium; then saturates to the value width.
// ----------------------------------------------------------------------------
module lbmc_relax (
	input  lbmc_pkg::kind_t  kind,
	input  lbmc_pkg::value_t f,
	input  lbmc_pkg::value_t f_opp,
	input  lbmc_pkg::eq_t    eq,
	input  lbmc_pkg::cfg_t   cfg,
	output lbmc_pkg::value_t g
);

	localparam int W_W   = lbmc_pkg::INV_TAU_W + 2;
	localparam int ACC_W = lbmc_pkg::EQ_W + W_W + 1;
	localparam int PRE_W = ACC_W - lbmc_pkg::FRAC_W;

	localparam logic signed [PRE_W-1:0] SAT_HI = PRE_W'((64'sd1 <<< (lbmc_pkg::VALUE_W - 1)) - 1);
	localparam logic signed [PRE_W-1:0] SAT_LO = -SAT_HI - PRE_W'(1);
	localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< (lbmc_pkg::FRAC_W - 1);
	localparam logic signed [W_W-1:0]   ONE_W  = W_W'(lbmc_pkg::ONE_Q13);

	logic signed [W_W-1:0]   mul_a;
	logic signed [ACC_W-1:0] mul_b;
	logic signed [W_W-1:0]   eq_w;
	logic signed [ACC_W-1:0] acc;
	logic signed [PRE_W-1:0] pre;
	logic                    use_eq;

	// Pick the operands of the shared weighting multiply
	always_comb begin
		mul_a  = ONE_W - $signed({2'b00, cfg.inv_tau});
		mul_b  = ACC_W'(f);
		eq_w   = $signed({2'b00, cfg.inv_tau});
		use_eq = 1'b0;
		case (kind)
			lbmc_pkg::KIND_WALL: begin
				mul_a = $signed(W_W'({1'b0, cfg.damping}));
				mul_b = ACC_W'(f_opp);
				eq_w  = '0;
			end
			lbmc_pkg::KIND_SOURCE: begin
				use_eq = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Weight, round half up, drop the fraction
	always_comb begin
		acc = ACC_W'(mul_a) * mul_b + ACC_W'(eq_w) * ACC_W'(eq) + RND;
		pre = use_eq ? PRE_W'(eq) : PRE_W'(acc >>> lbmc_pkg::FRAC_W);
	end

	// Clamp to the signed value range
	always_comb begin
		if (pre > SAT_HI) begin
			g = lbmc_pkg::VALUE_W'(SAT_HI);
		end else if (pre < SAT_LO) begin
			g = lbmc_pkg::VALUE_W'(SAT_LO);
		end else begin
			g = lbmc_pkg::VALUE_W'(pre);
		end
	end

endmodule

// File: hw/rtl/lbm_d2q5_cell_collision_core.sv
// ----------------------------------------------------------------------------
// lbm_d2q5_cell_collision_core
// D2Q5 lattice Boltzmann collision of one cell per word: interior relaxation,
// source equilibrium and damped wall bounce-back, saturating Q2.13.
// ----------------------------------------------------------------------------
// Throughput: one cell per cycle while the output is not stalled; three register
// stages (input, equilibrium, result) advance independently, so bubbles close up
// under output stall.
// Reset: arst_n clears all valid flags and loads inv_tau = 16384 and
// damping = 7782; no clearing pass, the block is ready right after reset.
// ----------------------------------------------------------------------------
module lbm_d2q5_cell_collision_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Cell word in
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [lbmc_pkg::VALUE_W-1:0]   f_rest,
	input  logic signed [lbmc_pkg::VALUE_W-1:0]   f_east,
	input  logic signed [lbmc_pkg::VALUE_W-1:0]   f_north,
	input  logic signed [lbmc_pkg::VALUE_W-1:0]   f_west,
	input  logic signed [lbmc_pkg::VALUE_W-1:0]   f_south,
	input  logic        [lbmc_pkg::KIND_W-1:0]    cell_kind,
	input  logic signed [lbmc_pkg::SRC_W-1:0]     source_value,
	// Result word out
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [lbmc_pkg::VALUE_W-1:0]   g_rest,
	output logic signed [lbmc_pkg::VALUE_W-1:0]   g_east,
	output logic signed [lbmc_pkg::VALUE_W-1:0]   g_north,
	output logic signed [lbmc_pkg::VALUE_W-1:0]   g_west,
	output logic signed [lbmc_pkg::VALUE_W-1:0]   g_south,
	// Register writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [lbmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [lbmc_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int RHO_W = lbmc_pkg::RHO_W;
	localparam int J_W   = lbmc_pkg::J_W;
	localparam int NUM_W = RHO_W + 18;

	localparam logic signed [NUM_W-1:0] C2_N   = NUM_W'(lbmc_pkg::C2_Q16);
	localparam logic signed [NUM_W-1:0] AUX0_N = NUM_W'(lbmc_pkg::AUX0_X2_Q16);
	localparam logic signed [NUM_W-1:0] RND_N  = NUM_W'(1) <<< (lbmc_pkg::EQ_SHIFT - 1);

	// Registers
	lbmc_pkg::cfg_t cfg_q;

	// Stage valids and handshake
	logic v_s1;
	logic v_s2;
	logic out_valid_q;
	logic out_free;
	logic free_s2;
	logic free_s1;

	// Stage 1: the input word
	lbmc_pkg::value_t fr_s1, fe_s1, fn_s1, fw_s1, fs_s1;
	lbmc_pkg::kind_t  kind_s1;
	logic signed [lbmc_pkg::SRC_W-1:0] src_s1;

	// Moments and equilibrium
	logic signed [RHO_W-1:0] rho;
	logic signed [RHO_W-1:0] dens;
	logic signed [J_W-1:0]   jx;
	logic signed [J_W-1:0]   jy;
	logic signed [NUM_W-1:0] c2_term;
	logic signed [NUM_W-1:0] jx_term;
	logic signed [NUM_W-1:0] jy_term;
	lbmc_pkg::eq_t eq_r, eq_e, eq_n, eq_w, eq_s;

	// Stage 2: distributions and equilibria
	lbmc_pkg::value_t fr_s2, fe_s2, fn_s2, fw_s2, fs_s2;
	lbmc_pkg::kind_t  kind_s2;
	lbmc_pkg::eq_t    eqr_s2, eqe_s2, eqn_s2, eqw_s2, eqs_s2;

	// Lane results and output register
	lbmc_pkg::value_t gr, ge, gn, gw, gs;
	lbmc_pkg::value_t gr_q, ge_q, gn_q, gw_q, gs_q;

	// Accept register writes at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_tau <= lbmc_pkg::INV_TAU_RST;
			cfg_q.damping <= lbmc_pkg::DAMP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lbmc_pkg::REG_INV_TAU: cfg_q.inv_tau <= cfg_data[lbmc_pkg::INV_TAU_W-1:0];
				lbmc_pkg::REG_DAMPING: cfg_q.damping <= cfg_data[lbmc_pkg::DAMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Advance each stage when the one after it is empty or moving
	assign out_free = !out_valid_q || !out_stall;
	assign free_s2  = !v_s2 || out_free;
	assign free_s1  = !v_s1 || free_s2;
	assign in_stall = !free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free_s1) begin
				v_s1 <= in_valid;
			end
			if (free_s2) begin
				v_s2 <= v_s1;
			end
			if (out_free) begin
				out_valid_q <= v_s2;
			end
		end
	end

	// Capture the input word
	always_ff @(posedge clk) begin
		if (free_s1 && in_valid) begin
			fr_s1   <= f_rest;
			fe_s1   <= f_east;
			fn_s1   <= f_north;
			fw_s1   <= f_west;
			fs_s1   <= f_south;
			kind_s1 <= cell_kind;
			src_s1  <= source_value;
		end
	end

	// Density and momenta; a source cell takes the imposed density
	always_comb begin
		rho  = RHO_W'(fr_s1) + RHO_W'(fe_s1) + RHO_W'(fn_s1) + RHO_W'(fw_s1) + RHO_W'(fs_s1);
		jx   = J_W'(fe_s1) - J_W'(fw_s1);
		jy   = J_W'(fn_s1) - J_W'(fs_s1);
		dens = (kind_s1 == lbmc_pkg::KIND_SOURCE) ? RHO_W'(src_s1) : rho;
	end

	// Equilibria, rounded half up at scale 2^17
	always_comb begin
		c2_term = NUM_W'(dens) * C2_N;
		jx_term = NUM_W'(jx) <<< 16;
		jy_term = NUM_W'(jy) <<< 16;
		eq_r = lbmc_pkg::EQ_W'((NUM_W'(dens) * AUX0_N + RND_N) >>> lbmc_pkg::EQ_SHIFT);
		eq_e = lbmc_pkg::EQ_W'((c2_term + jx_term + RND_N) >>> lbmc_pkg::EQ_SHIFT);
		eq_n = lbmc_pkg::EQ_W'((c2_term + jy_term + RND_N) >>> lbmc_pkg::EQ_SHIFT);
		eq_w = lbmc_pkg::EQ_W'((c2_term - jx_term + RND_N) >>> lbmc_pkg::EQ_SHIFT);
		eq_s = lbmc_pkg::EQ_W'((c2_term - jy_term + RND_N) >>> lbmc_pkg::EQ_SHIFT);
	end

	always_ff @(posedge clk) begin
		if (free_s2 && v_s1) begin
			fr_s2   <= fr_s1;
			fe_s2   <= fe_s1;
			fn_s2   <= fn_s1;
			fw_s2   <= fw_s1;
			fs_s2   <= fs_s1;
			kind_s2 <= kind_s1;
			eqr_s2  <= eq_r;
			eqe_s2  <= eq_e;
			eqn_s2  <= eq_n;
			eqw_s2  <= eq_w;
			eqs_s2  <= eq_s;
		end
	end

	// One lane per direction; walls reflect the opposite direction
	lbmc_relax u_relax_rest (
		.kind(kind_s2), .f(fr_s2), .f_opp(fr_s2), .eq(eqr_s2), .cfg(cfg_q), .g(gr)
	);
	lbmc_relax u_relax_east (
		.kind(kind_s2), .f(fe_s2), .f_opp(fw_s2), .eq(eqe_s2), .cfg(cfg_q), .g(ge)
	);
	lbmc_relax u_relax_north (
		.kind(kind_s2), .f(fn_s2), .f_opp(fs_s2), .eq(eqn_s2), .cfg(cfg_q), .g(gn)
	);
	lbmc_relax u_relax_west (
		.kind(kind_s2), .f(fw_s2), .f_opp(fe_s2), .eq(eqw_s2), .cfg(cfg_q), .g(gw)
	);
	lbmc_relax u_relax_south (
		.kind(kind_s2), .f(fs_s2), .f_opp(fn_s2), .eq(eqs_s2), .cfg(cfg_q), .g(gs)
	);

	// Hold the result word until taken
	always_ff @(posedge clk) begin
		if (out_free && v_s2) begin
			gr_q <= gr;
			ge_q <= ge;
			gn_q <= gn;
			gw_q <= gw;
			gs_q <= gs;
		end
	end

	assign out_valid = out_valid_q;
	assign g_rest    = gr_q;
	assign g_east    = ge_q;
	assign g_north   = gn_q;
	assign g_west    = gw_q;
	assign g_south   = gs_q;

endmodule

// File: hw/rtl/lbmc_checker.sv
// ----------------------------------------------------------------------------
// lbmc_checker
// Port-level checks of the collision core, bound to the top level.
// ----------------------------------------------------------------------------
`include "lbm_d2q5_cell_collision_core_assert.svh"

module lbmc_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_stall,
	input logic signed [lbmc_pkg::VALUE_W-1:0]    f_rest,
	input logic signed [lbmc_pkg::VALUE_W-1:0]    f_east,
	input logic signed [lbmc_pkg::VALUE_W-1:0]    f_north,
	input logic signed [lbmc_pkg::VALUE_W-1:0]    f_west,
	input logic signed [lbmc_pkg::VALUE_W-1:0]    f_south,
	input logic        [lbmc_pkg::KIND_W-1:0]     cell_kind,
	input logic signed [lbmc_pkg::SRC_W-1:0]      source_value,
	input logic                                   out_valid,
	input logic                                   out_stall,
	input logic signed [lbmc_pkg::VALUE_W-1:0]    g_rest,
	input logic signed [lbmc_pkg::VALUE_W-1:0]    g_east,
	input logic signed [lbmc_pkg::VALUE_W-1:0]    g_north,
	input logic signed [lbmc_pkg::VALUE_W-1:0]    g_west,
	input logic signed [lbmc_pkg::VALUE_W-1:0]    g_south,
	input logic                                   cfg_valid,
	input logic                                   cfg_ready,
	input logic        [lbmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic        [lbmc_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Reset empties the output register
	`LBMC_ASSERT_RST(a_reset_empty, !arst_n |=> !out_valid, "output valid after reset")

	// With the output empty the whole pipeline drains, so input never stalls
	`LBMC_ASSERT(a_no_stall_empty, !out_valid |-> !in_stall, "input stalled while output empty")

	// A fresh result follows a word that passed the input, equilibrium and result registers
	`LBMC_ASSERT(a_latency, $rose(out_valid) |-> $past(in_valid && !in_stall, 3), "result without matching word")

	// Register writes are never held off
	`LBMC_ASSERT(a_cfg_ready, cfg_ready, "register write port not ready")

endmodule

bind lbm_d2q5_cell_collision_core lbmc_checker u_lbmc_checker (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the D2Q5 cell collision core. Cell words go in with
// random gaps and random output stall, and every result word is compared field
// by field with a behavioral collision model kept in step with the weight
// registers. A short directed table covers value extremes, every cell kind and
// unit weights; random phases then sweep in-range and out-of-range weights.
// ----------------------------------------------------------------------------
module testbench;
	import lbmc_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int RAND_PHASES  = 8;
	localparam int RESET_CELLS  = 60;
	localparam int PHASE_CELLS  = 105;
	localparam int REPORT_MAX   = 10;
	localparam int DRAIN_CYCLES = 6;

	// Register indexes the core does not decode
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	// Unused kind code, handled like an interior cell
	localparam kind_t KIND_SPARE = 2'd3;

	// Direction slots
	localparam int DIR_REST  = 0;
	localparam int DIR_EAST  = 1;
	localparam int DIR_NORTH = 2;
	localparam int DIR_WEST  = 3;
	localparam int DIR_SOUTH = 4;

	// Momentum term of the equilibrium at scale 2^16
	localparam longint MOM_SCALE = 65536;

	localparam value_t V_MAX = 16'sh7FFF;
	localparam value_t V_MIN = 16'sh8000;

	typedef logic signed [SRC_W-1:0] src_t;

	typedef struct packed {
		kind_t  kind;
		value_t f_rest, f_east, f_north, f_west, f_south;
		src_t   src;
	} cell_t;

	typedef struct packed {
		value_t rest, east, north, west, south;
	} dist_t;

	typedef struct packed {
		cell_t stim;
		logic  typed;
		dist_t want;
	} row_t;

	localparam dist_t NO_DIST = '0;

	// Directed cells, run with inv_tau = 0 and damping = 1.0: interior and
	// spare-kind cells pass through, wall cells swap opposite directions
	localparam int N_DIRECTED = 16;
	localparam row_t DIRECTED [N_DIRECTED] = '{
		'{'{KIND_INTERIOR, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'sd0}, 1'b1,
			'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}},
		'{'{KIND_INTERIOR, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, 15'sd0}, 1'b1,
			'{V_MAX, V_MAX, V_MAX, V_MAX, V_MAX}},
		'{'{KIND_INTERIOR, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, 15'sd0}, 1'b1,
			'{V_MIN, V_MIN, V_MIN, V_MIN, V_MIN}},
		'{'{KIND_INTERIOR, V_MAX, V_MIN, 16'sd1, -16'sd1, 16'sd12345, 15'sd0}, 1'b1,
			'{V_MAX, V_MIN, 16'sd1, -16'sd1, 16'sd12345}},
		'{'{KIND_SPARE, -16'sd2, 16'sd3000, -16'sd3000, V_MAX, V_MIN, 15'sd100}, 1'b1,
			'{-16'sd2, 16'sd3000, -16'sd3000, V_MAX, V_MIN}},
		'{'{KIND_WALL, 16'sd100, 16'sd200, 16'sd300, 16'sd400, 16'sd500, 15'sd0}, 1'b1,
			'{16'sd100, 16'sd400, 16'sd500, 16'sd200, 16'sd300}},
		'{'{KIND_WALL, V_MAX, V_MAX, V_MIN, V_MIN, 16'sd7, 15'sd0}, 1'b1,
			'{V_MAX, V_MIN, 16'sd7, V_MAX, V_MIN}},
		'{'{KIND_WALL, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, 15'sd0}, 1'b1,
			'{V_MIN, V_MIN, V_MIN, V_MIN, V_MIN}},
		'{'{KIND_WALL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -15'sd1}, 1'b1,
			'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}},
		'{'{KIND_SOURCE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'sd8192}, 1'b0, NO_DIST},
		'{'{KIND_SOURCE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -15'sd8192}, 1'b0, NO_DIST},
		'{'{KIND_SOURCE, 16'sd0, V_MAX, 16'sd0, V_MIN, 16'sd0, 15'sd0}, 1'b0, NO_DIST},
		'{'{KIND_SOURCE, 16'sd0, 16'sd0, V_MIN, 16'sd0, V_MAX, 15'sh4000}, 1'b0, NO_DIST},
		'{'{KIND_SOURCE, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, 15'sh3FFF}, 1'b0, NO_DIST},
		'{'{KIND_SOURCE, 16'sd1, -16'sd1, 16'sd2, -16'sd2, 16'sd3, -15'sd1}, 1'b0, NO_DIST},
		'{'{KIND_SOURCE, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, -15'sd4096}, 1'b0, NO_DIST}
	};

	logic   clk          = 1'b0;
	logic   arst_n       = 1'b0;
	logic   in_valid     = 1'b0;
	logic   in_stall;
	value_t f_rest       = '0;
	value_t f_east       = '0;
	value_t f_north      = '0;
	value_t f_west       = '0;
	value_t f_south      = '0;
	kind_t  cell_kind    = KIND_INTERIOR;
	src_t   source_value = '0;
	logic   out_valid;
	logic   out_stall    = 1'b0;
	value_t g_rest, g_east, g_north, g_west, g_south;
	logic   cfg_valid    = 1'b0;
	logic   cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_INV_TAU;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Weight registers as the core should hold them
	logic [INV_TAU_W-1:0] tau_q  = INV_TAU_RST;
	logic [DAMP_W-1:0]    damp_q = DAMP_RST;

	dist_t post_collision_q [$];
	dist_t want_word, seen_word;
	int    mismatch_count = 0;
	int    cycle_count    = 0;
	int    stall_hold     = 0;
	int    stall_pick;
	logic  in_quiet  = 1'b0;
	logic  out_quiet = 1'b0;

	lbm_d2q5_cell_collision_core i_dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// Round to nearest, halves up, on a right shift by s
	function automatic longint round_q(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic value_t clip(input longint v);
		if (v > longint'(V_MAX))
			return V_MAX;
		if (v < longint'(V_MIN))
			return V_MIN;
		return value_t'(v);
	endfunction

	function automatic longint equil(input longint rho, input longint jx, input longint jy,
			input int d);
		case (d)
			DIR_REST:  return round_q(longint'(AUX0_X2_Q16) * rho, EQ_SHIFT);
			DIR_EAST:  return round_q(longint'(C2_Q16) * rho + MOM_SCALE * jx, EQ_SHIFT);
			DIR_NORTH: return round_q(longint'(C2_Q16) * rho + MOM_SCALE * jy, EQ_SHIFT);
			DIR_WEST:  return round_q(longint'(C2_Q16) * rho - MOM_SCALE * jx, EQ_SHIFT);
			default:   return round_q(longint'(C2_Q16) * rho - MOM_SCALE * jy, EQ_SHIFT);
		endcase
	endfunction

	// Post-collision distributions of one cell under the given weights
	function automatic dist_t collide(input cell_t c, input logic [INV_TAU_W-1:0] w_tau,
			input logic [DAMP_W-1:0] w_damp);
		longint f [5];
		longint g [5];
		longint rho, jx, jy, src, eq, w;
		int     opp;
		dist_t  o;
		f[DIR_REST]  = longint'($signed(c.f_rest));
		f[DIR_EAST]  = longint'($signed(c.f_east));
		f[DIR_NORTH] = longint'($signed(c.f_north));
		f[DIR_WEST]  = longint'($signed(c.f_west));
		f[DIR_SOUTH] = longint'($signed(c.f_south));
		src = longint'($signed(c.src));
		w   = longint'(w_tau);
		rho = f[DIR_REST] + f[DIR_EAST] + f[DIR_NORTH] + f[DIR_WEST] + f[DIR_SOUTH];
		jx  = f[DIR_EAST] - f[DIR_WEST];
		jy  = f[DIR_NORTH] - f[DIR_SOUTH];
		for (int d = 0; d < 5; d++) begin
			if (c.kind == KIND_WALL) begin
				// bounce back from the opposite direction, rest reflects itself
				opp = (d == DIR_REST) ? DIR_REST : ((d + 1) % 4) + 1;
				g[d] = round_q(longint'(w_damp) * f[opp], FRAC_W);
			end else if (c.kind == KIND_SOURCE) begin
				g[d] = equil(src, jx, jy, d);
			end else begin
				eq = equil(rho, jx, jy, d);
				g[d] = round_q((longint'(ONE_Q13) - w) * f[d] + w * eq, FRAC_W);
			end
		end
		o.rest  = clip(g[DIR_REST]);
		o.east  = clip(g[DIR_EAST]);
		o.north = clip(g[DIR_NORTH]);
		o.west  = clip(g[DIR_WEST]);
		o.south = clip(g[DIR_SOUTH]);
		return o;
	endfunction

	// Mix of full-range, moderate and extreme distribution values
	function automatic value_t pick_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return value_t'($urandom);
		if (r < 85)
			return value_t'($urandom_range(0, 8192) - 4096);
		case ($urandom_range(0, 3))
			0:       return V_MAX;
			1:       return V_MIN;
			2:       return '0;
			default: return -16'sd1;
		endcase
	endfunction

	function automatic cell_t random_cell();
		cell_t       c;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			c.kind = KIND_INTERIOR;
		else if (r < 65)
			c.kind = KIND_WALL;
		else if (r < 90)
			c.kind = KIND_SOURCE;
		else
			c.kind = KIND_SPARE;
		c.f_rest  = pick_value();
		c.f_east  = pick_value();
		c.f_north = pick_value();
		c.f_west  = pick_value();
		c.f_south = pick_value();
		// mostly the nominal source range, sometimes any 15-bit value
		if ($urandom_range(0, 4) == 0)
			c.src = src_t'($urandom);
		else
			c.src = src_t'($urandom_range(0, 16384) - 8192);
		return c;
	endfunction

	// Mostly back to back, some short gaps, a few long ones
	function automatic int unsigned idle_len(input logic quiet);
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Drive one cell word, hold it until accepted, then queue its expected result
	task automatic send_cell(input cell_t c, input logic typed, input dist_t want);
		int unsigned gap;
		gap = idle_len(in_quiet);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		cell_kind    <= c.kind;
		f_rest       <= c.f_rest;
		f_east       <= c.f_east;
		f_north      <= c.f_north;
		f_west       <= c.f_west;
		f_south      <= c.f_south;
		source_value <= c.src;
		do @(posedge clk); while (in_stall);
		post_collision_q.push_back(typed ? want : collide(c, tau_q, damp_q));
	endtask

	// Write one register; cfg_valid stays high for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_INV_TAU)
			tau_q = data[INV_TAU_W-1:0];
		else if (idx == REG_DAMPING)
			damp_q = data[DAMP_W-1:0];
	endtask

	// Load both weights, each followed by a write to an undecoded index
	task automatic set_weights(input logic [INV_TAU_W-1:0] tau, input logic [DAMP_W-1:0] damp);
		write_reg(REG_INV_TAU, CFG_DATA_W'(tau));
		write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
		write_reg(REG_DAMPING, {1'($urandom), damp});
		write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Stop sending and let every outstanding result drain
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (post_collision_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string name, input value_t want, input value_t got);
		if (want !== got) begin
			if (mismatch_count < REPORT_MAX)
				$display("mismatch %s at cycle %0d: expected %0d, got %0d",
					name, cycle_count, want, got);
			mismatch_count++;
		end
	endtask

	// Output stall: runs of release, short stalls and a few long ones
	always @(posedge clk) begin
		if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else if (out_quiet) begin
			out_stall <= 1'b0;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 50) begin
				out_stall  <= 1'b0;
				stall_hold <= $urandom_range(0, 20);
			end else if (stall_pick < 90) begin
				out_stall  <= 1'b1;
				stall_hold <= $urandom_range(0, 3);
			end else begin
				out_stall  <= 1'b1;
				stall_hold <= $urandom_range(10, 40);
			end
		end
	end

	// Compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_word = '{g_rest, g_east, g_north, g_west, g_south};
			if (post_collision_q.size() == 0) begin
				if (mismatch_count < REPORT_MAX)
					$display("unexpected result word at cycle %0d: %0d %0d %0d %0d %0d",
						cycle_count, g_rest, g_east, g_north, g_west, g_south);
				mismatch_count++;
			end else begin
				want_word = post_collision_q.pop_front();
				check_field("g_rest", want_word.rest, seen_word.rest);
				check_field("g_east", want_word.east, seen_word.east);
				check_field("g_north", want_word.north, seen_word.north);
				check_field("g_west", want_word.west, seen_word.west);
				check_field("g_south", want_word.south, seen_word.south);
			end
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [INV_TAU_W-1:0] tau_pick;
		logic [DAMP_W-1:0]    damp_pick;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Random cells on the reset weights
		for (int k = 0; k < RESET_CELLS; k++)
			send_cell(random_cell(), 1'b0, NO_DIST);
		wait_drain();

		// Directed table on unit weights
		set_weights(INV_TAU_W'(0), DAMP_W'(8192));
		for (int k = 0; k < N_DIRECTED; k++)
			send_cell(DIRECTED[k].stim, DIRECTED[k].typed, DIRECTED[k].want);
		wait_drain();

		// Random phases: fixed weights first (reset, all ones, all zeros, mid values), then random ones
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: begin
					tau_pick  = INV_TAU_RST;
					damp_pick = DAMP_RST;
				end
				1: begin
					tau_pick  = '1;
					damp_pick = '1;
				end
				2: begin
					tau_pick  = '0;
					damp_pick = '0;
				end
				3: begin
					tau_pick  = INV_TAU_W'(8192);
					damp_pick = DAMP_W'(4096);
				end
				default: begin
					if ($urandom_range(0, 3) == 0)
						tau_pick = INV_TAU_W'($urandom);
					else
						tau_pick = INV_TAU_W'($urandom_range(0, 16384));
					if ($urandom_range(0, 3) == 0)
						damp_pick = DAMP_W'($urandom);
					else
						damp_pick = DAMP_W'($urandom_range(0, 8192));
				end
			endcase
			set_weights(tau_pick, damp_pick);
			in_quiet  = (p % 3 == 1);
			out_quiet <= (p % 4 == 2);
			for (int k = 0; k < PHASE_CELLS; k++) begin
				// hold off mid-phase until the pipe is empty
				if (k == PHASE_CELLS / 2)
					wait_drain();
				send_cell(random_cell(), 1'b0, NO_DIST);
			end
			wait_drain();
		end

		if (mismatch_count == 0 && post_collision_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/lbmc_pkg.sv
hw/rtl/lbmc_relax.sv
hw/rtl/lbm_d2q5_cell_collision_core.sv
hw/rtl/lbmc_checker.sv
tb/sv/testbench.sv
